// ===== hdl/jbee_pkg.sv =====
// Package for the baseline entropy encoder: shared types, state codes and Huffman code tables.
// The code memory, packer, sequencer and top level import it. It depends on nothing else.
package jbee_pkg;

  // Entry of a code table: length in the upper five bits, code in the lower sixteen.
  typedef logic [20:0] code_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_BITS,
    ST_DRAIN,
    ST_FLUSH
  } enc_state_t;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam int unsigned AC_MAX = 1023;

  // Builds the canonical Annex K code for one symbol, found by walking the count list.
  function automatic code_entry_t canon(input logic [1:0] tbl, input logic [7:0] sym);
    logic [7:0] cnt [0:15];
    logic [7:0] syms [0:161];
    int unsigned n, k, code, len, i;
    code_entry_t r;
    r = '0;
    k = 0;
    code = 0;
    for (i = 0; i < 162; i++) syms[i] = 8'h00;
    case (tbl)
      2'd0, 2'd2: begin
        for (i = 0; i < 12; i++) syms[i] = 8'(i);
        n = 12;
      end
      2'd1: begin
        n = 162;
        syms = '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
          8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'hA1,8'h08,
          8'h23,8'h42,8'hB1,8'hC1,8'h15,8'h52,8'hD1,8'hF0,8'h24,8'h33,8'h62,8'h72,
          8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,8'h19,8'h1A,8'h25,8'h26,8'h27,8'h28,
          8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3A,8'h43,8'h44,8'h45,
          8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
          8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,
          8'h76,8'h77,8'h78,8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
          8'h8A,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,
          8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,
          8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,
          8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,8'hE1,8'hE2,
          8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,8'hF2,8'hF3,8'hF4,
          8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};
      end
      default: begin
        n = 162;
        syms = '{8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,
          8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,
          8'hA1,8'hB1,8'hC1,8'h09,8'h23,8'h33,8'h52,8'hF0,8'h15,8'h62,8'h72,8'hD1,
          8'h0A,8'h16,8'h24,8'h34,8'hE1,8'h25,8'hF1,8'h17,8'h18,8'h19,8'h1A,8'h26,
          8'h27,8'h28,8'h29,8'h2A,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3A,8'h43,8'h44,
          8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
          8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,
          8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
          8'h88,8'h89,8'h8A,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,
          8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,
          8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,
          8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,
          8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF2,8'hF3,8'hF4,
          8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};
      end
    endcase
    case (tbl)
      2'd0: cnt = '{8'd0,8'd1,8'd5,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0,
                    8'd0,8'd0};
      2'd1: cnt = '{8'd0,8'd2,8'd1,8'd3,8'd3,8'd2,8'd4,8'd3,8'd5,8'd5,8'd4,8'd4,8'd0,8'd0,
                    8'd1,8'd125};
      2'd2: cnt = '{8'd0,8'd3,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,
                    8'd0,8'd0};
      default: cnt = '{8'd0,8'd2,8'd1,8'd2,8'd4,8'd4,8'd3,8'd4,8'd7,8'd5,8'd4,8'd4,8'd0,
                       8'd1,8'd2,8'd119};
    endcase
    for (len = 1; len <= 16; len++) begin
      for (i = 0; i < 256; i++) begin
        if (i < cnt[len-1] && k < n) begin
          if (syms[k] == sym) r = {5'(len), 16'(code)};
          code++;
          k++;
        end
      end
      code = code << 1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/jbee_if.sv =====
// Valid/ready channel with payload, used for input and output of the encoder.
// Depends on nothing; the payload is a parameterized type.
interface jbee_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/jbee_code_rom.sv =====
// Code table memory: 1024 entries of length and code, with a registered read.
// Uses jbee_pkg for the entry type and the table contents.
module jbee_code_rom import jbee_pkg::*; (
  input  logic        clk,
  input  logic [9:0]  addr,
  output code_entry_t entry
);

  code_entry_t mem [0:1023];

  // Fixed contents built from the canonical tables.
  always_comb begin
    for (int i = 0; i < 1024; i++) mem[i] = canon(2'(i >> 8), 8'(i));
  end

  always_ff @(posedge clk) begin
    entry <= mem[addr];
  end

endmodule

// ===== hdl/jbee_packer.sv =====
// Bit packer: appends up to 16 bits to a pending byte and hands out bytes with 0xFF stuffing.
// Uses jbee_pkg for constants.
module jbee_packer import jbee_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [15:0] bits,
  input  logic [4:0]  len,
  input  logic        pad,
  input  logic        take,
  output logic        busy,
  output logic [7:0]  byte_out,
  output logic        has_byte
);

  logic [22:0] acc;
  logic [4:0]  cnt;
  logic        stuff;
  logic [22:0] acc_next;
  logic [4:0]  cnt_next;
  logic [7:0]  head;

  assign head = 8'(acc >> (cnt - 5'd8));
  assign has_byte = stuff || cnt >= 5'd8;
  assign byte_out = stuff ? 8'h00 : head;
  assign busy = has_byte;

  always_comb begin
    acc_next = acc;
    cnt_next = cnt;
    if (load) begin
      acc_next = (acc << len) | 23'(bits & 16'((17'h1 << len) - 17'h1));
      cnt_next = cnt + len;
    end else if (pad && cnt != 5'd0) begin
      acc_next = (acc << (5'd8 - cnt)) | 23'((9'h1 << (5'd8 - cnt)) - 9'h1);
      cnt_next = 5'd8;
    end else if (pad) begin
      acc_next = '0;
    end
  end

  // One byte leaves per accepted take; stuffing holds the count for one extra word.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      stuff <= 1'b0;
    end else if (take && has_byte) begin
      if (stuff) begin
        stuff <= 1'b0;
      end else begin
        cnt <= cnt - 5'd8;
        acc <= acc & 23'((24'h1 << (cnt - 5'd8)) - 24'h1);
        stuff <= (head == BYTE_FF);
      end
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $rose(stuff) |-> $past(head) == BYTE_FF)
    else $error("stuffing without 0xFF");
  assert property (@(posedge clk) disable iff (rst) cnt <= 5'd23)
    else $error("packer overflow");
  assert property (@(posedge clk) disable iff (rst) load |-> !has_byte)
    else $error("load while bytes pending");

endmodule

// ===== hdl/jbee_ctrl.sv =====
// Sequencer: DC predictor and run-length coding, driving the code memory and the packer.
// Uses jbee_pkg for state codes and constants.
module jbee_ctrl import jbee_pkg::*; #(
  parameter int COEFF_LIMIT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [1:0]  component,
  input  logic [11:0] coefficient,
  output logic [9:0]  rom_addr,
  input  code_entry_t rom_entry,
  output logic        load,
  output logic [15:0] bits,
  output logic [4:0]  len,
  output logic        pad,
  input  logic        busy,
  output logic        item_done
);

  localparam logic signed [12:0] LIM = 13'(COEFF_LIMIT - 1);

  enc_state_t  state, state_next;
  logic signed [11:0] pred [0:2];
  logic [5:0]  zero_run;
  logic [5:0]  coeff_index;
  logic [1:0]  comp;
  logic signed [11:0] val;
  logic [3:0]  cat;
  logic        zrl_pending;
  logic        eob_only;
  logic        no_bits;
  logic signed [12:0] v_in, v_sat, diff, dsat, vac;
  logic [1:0]  comp_in;
  logic [3:0]  cat_in;
  logic [11:0] mag;
  logic [11:0] absv;

  assign comp_in = (component == 2'd3) ? 2'd2 : component;
  assign v_in = 13'(signed'(coefficient));
  assign v_sat = (v_in > LIM) ? LIM : (v_in < -LIM) ? -LIM : v_in;
  assign diff = v_sat - 13'(pred[comp_in]);
  assign dsat = (diff > LIM) ? LIM : (diff < -LIM) ? -LIM : diff;
  assign vac = (v_sat > 13'sd1023) ? 13'sd1023 : (v_sat < -13'sd1023) ? -13'sd1023 : v_sat;

  // Magnitude category of the value that will be coded.
  always_comb begin
    logic signed [12:0] x;
    x = (coeff_index == 6'd0) ? dsat : vac;
    absv = 12'(x < 0 ? -x : x);
    cat_in = 4'd0;
    for (int i = 0; i < 12; i++) if (absv[i]) cat_in = 4'(i + 1);
  end

  assign mag = (val >= 0) ? 12'(val) : 12'(val + 12'sd1 * 12'((13'h1 << cat) - 13'h1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = mode ? ST_FLUSH :
          (coeff_index != 6'd0 && v_sat == 0 && coeff_index != 6'd63) ? ST_IDLE : ST_LOOK;
      ST_LOOK: state_next = (!zrl_pending && (no_bits || eob_only)) ? ST_DRAIN : ST_BITS;
      ST_BITS: state_next = busy ? ST_BITS : (zrl_pending ? ST_LOOK : ST_DRAIN);
      ST_FLUSH: state_next = ST_DRAIN;
      ST_DRAIN: state_next = busy ? ST_DRAIN : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs. While a ZRL is in the packer, the memory already fetches the code that
  // follows it: another ZRL if at least 16 zeros remain after it, else the run and size symbol.
  // The item's last bits are in the packer once the sequencer reaches the drain state.
  always_comb begin
    in_ready = (state == ST_IDLE);
    load = 1'b0;
    pad = 1'b0;
    bits = rom_entry[15:0];
    len = rom_entry[20:16];
    item_done = 1'b0;
    rom_addr = {comp != 2'd0, 1'b1, (zrl_pending && zero_run >= 6'd32) ? SYM_ZRL :
                {zero_run[3:0], cat}};
    if (state == ST_IDLE && in_valid) begin
      rom_addr = {comp_in != 2'd0, coeff_index != 6'd0, (coeff_index == 6'd0) ? {4'd0, cat_in} :
                  (v_sat == 0) ? SYM_EOB : (zero_run >= 6'd16) ? SYM_ZRL :
                  {zero_run[3:0], cat_in}};
    end
    case (state)
      ST_LOOK: load = !busy;
      ST_BITS: begin
        load = !busy && !zrl_pending;
        bits = 16'(mag);
        len = {1'b0, cat};
      end
      ST_FLUSH: pad = 1'b1;
      ST_DRAIN: item_done = 1'b1;
      default: ;
    endcase
  end

  assign no_bits = (cat == 4'd0);

  // Item state, predictors and run tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      coeff_index <= '0;
      zero_run <= '0;
      zrl_pending <= 1'b0;
      eob_only <= 1'b0;
      for (int i = 0; i < 3; i++) pred[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        comp <= comp_in;
        cat <= cat_in;
        eob_only <= 1'b0;
        zrl_pending <= 1'b0;
        if (mode) begin
          coeff_index <= '0;
          zero_run <= '0;
          for (int i = 0; i < 3; i++) pred[i] <= '0;
        end else if (coeff_index == 6'd0) begin
          val <= 12'(dsat);
          pred[comp_in] <= 12'(v_sat);
          coeff_index <= 6'd1;
        end else begin
          coeff_index <= coeff_index + 6'd1;
          val <= 12'(vac);
          if (v_sat == 0) begin
            zero_run <= (coeff_index == 6'd63) ? 6'd0 : zero_run + 6'd1;
            eob_only <= 1'b1;
          end else begin
            zrl_pending <= (zero_run >= 6'd16);
          end
        end
      end else if (state == ST_BITS && !busy && zrl_pending) begin
        zero_run <= zero_run - 6'd16;
        zrl_pending <= (zero_run >= 6'd32);
      end else if (state == ST_BITS && !busy) begin
        zero_run <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) load |-> !busy)
    else $error("load into busy packer");
  assert property (@(posedge clk) disable iff (rst) (load && pad) == 1'b0)
    else $error("load and pad together");
  assert property (@(posedge clk) disable iff (rst) zrl_pending |-> zero_run >= 6'd16)
    else $error("ZRL with short run");

endmodule

// ===== hdl/jpeg_baseline_entropy_encoder_top.sv =====
// Channel     Dir  Payload
// in_ch       in   mode, component, coefficient
// out_ch      out  out_byte, last
// Zero AC items before the last position are only added to the run. Other items pass through
// accept, code fetch or pad, and drain, plus a magnitude bits step and a further bits and fetch
// step per ZRL; output words leave through a one-word output register.
// Reset is synchronous and clears all control state; the code table needs no init.
// A stalled output holds the packer's bytes and a draining sequencer until the word is taken.
// Top level of the entropy encoder; depends on jbee_pkg, jbee_if and the submodules.
module jpeg_baseline_entropy_encoder_top import jbee_pkg::*; #(
  parameter int COEFF_LIMIT = 2048
) (
  input  logic clk,
  input  logic rst,
  jbee_if.sink   in_ch,
  jbee_if.source out_ch
);

  logic [9:0]  rom_addr;
  code_entry_t rom_entry;
  logic        load, pad, busy, has_byte, item_done, take;
  logic [15:0] bits;
  logic [4:0]  len;
  logic [7:0]  byte_out;
  logic        last_flag;
  logic        ctrl_busy;
  logic        out_fire;
  logic        held_valid;
  logic [7:0]  held_byte;

  jbee_code_rom u_rom (.clk, .addr(rom_addr), .entry(rom_entry));

  jbee_ctrl #(.COEFF_LIMIT(COEFF_LIMIT)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .mode(in_ch.data.mode), .component(in_ch.data.component),
    .coefficient(in_ch.data.coefficient),
    .rom_addr, .rom_entry, .load, .bits, .len, .pad, .busy(ctrl_busy), .item_done
  );

  jbee_packer u_pack (
    .clk, .rst, .load, .bits, .len, .pad, .take, .busy, .byte_out, .has_byte
  );

  // Last word of an item: nothing more will follow once this one leaves.
  assign last_flag = item_done && !has_byte;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign take = !held_valid || out_fire;
  assign ctrl_busy = busy || (held_valid && item_done);
  assign out_ch.valid = held_valid && (has_byte || last_flag);
  assign out_ch.data.out_byte = held_byte;
  assign out_ch.data.last = last_flag;

  // Output register: a word leaves once the next one exists or the item has ended.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take && has_byte) begin
      held_valid <= 1'b1;
      held_byte <= byte_out;
    end else if (out_fire) begin
      held_valid <= 1'b0;
    end
  end

endmodule
